[design/tbfd_pkg.sv]
// ----------------------------------------------------------------------------
// tbfd_pkg - shared types and constants for the length-prefix deframer
// Holds the result record, the queue entry, the parser phases and the
// prefix and result codes used by the front, queue and back modules.
// ----------------------------------------------------------------------------
package tbfd_pkg;

    // Width of the field_length result
    localparam int LEN_W = 24;

    // Decoupling queue between parser and result issue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Prefix codes
    localparam logic [7:0] PREFIX_EXT = 8'hFE;
    localparam logic [7:0] PREFIX_BAD = 8'hFF;

    // Index of the last byte of the 24-bit extended length
    localparam logic [1:0] EXT_LAST_IDX = 2'd2;

    // Error codes
    localparam logic ERR_BAD_PREFIX = 1'b0;
    localparam logic ERR_TRUNCATED  = 1'b1;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        PH_PREFIX  = 3'd0,
        PH_EXTLEN  = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_PAD     = 3'd3,
        PH_DROP    = 3'd4
    } t_phase;

    typedef struct packed {
        t_kind             kind;
        logic [7:0]        payload_byte;
        logic [LEN_W-1:0]  field_length;
        logic              error_code;
    } t_result;

    // One queue entry: every result that a single input byte causes
    typedef struct packed {
        logic    two;
        t_result r0;
        t_result r1;
    } t_op;

endpackage

[design/tbfd_if.sv]
// ----------------------------------------------------------------------------
// tbfd_if - stream channels of the deframer
// Byte input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tbfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_end;

    modport source (output valid, output data_byte, output buffer_end, input ready);
    modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface tbfd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [23:0] field_length;
    logic        error_code;
    logic        last_of_run;

    modport source (output valid, output kind, output payload_byte, output field_length,
                    output error_code, output last_of_run, input ready);
    modport sink   (input valid, input kind, input payload_byte, input field_length,
                    input error_code, input last_of_run, output ready);
endinterface

[design/tbfd_front.sv]
// ----------------------------------------------------------------------------
// tbfd_front - prefix parser
// Accepts one byte per cycle unless the queue is full, tracks the field phase
// and offset, and packs the results the byte causes into one queue entry.
// ----------------------------------------------------------------------------
module tbfd_front
    import tbfd_pkg::*;
#(
    parameter int LENGTH_BITS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tbfd_in_if.sink       i_in,
    input  logic          i_full,
    output logic          o_push,
    output t_op           o_op
);

    t_phase                 r_phase, n_phase, w_step_phase;
    logic [LENGTH_BITS-1:0] r_field_len, n_field_len;
    logic [LENGTH_BITS-1:0] r_bytes_left, n_bytes_left;
    logic [1:0]             r_off, n_off;
    logic [1:0]             r_idx, n_idx;

    logic                   w_acc;
    logic [7:0]             w_b;
    logic                   w_end;
    logic [LEN_W-1:0]       w_ext_byte;
    logic [LENGTH_BITS-1:0] w_ext_len;
    logic [LENGTH_BITS-1:0] w_pfx_len;
    logic [LENGTH_BITS-1:0] w_bl_dec;
    logic [1:0]             w_o1;
    logic [1:0]             w_pad;
    logic                   w_pad0;
    logic                   w_short;
    logic                   w_ext_last;
    logic                   w_bl_one;
    logic                   w_fin;
    logic                   w_open;
    logic                   ev_byte, ev_done, ev_bad, ev_trunc;
    t_result                w_res_byte, w_res_done, w_res_bad, w_res_trunc;

    // Handshake
    assign i_in.ready = !i_full;
    assign w_acc      = i_in.valid && !i_full;
    assign w_b        = i_in.data_byte;
    assign w_end      = i_in.buffer_end;

    // Length assembly and offset arithmetic
    always_comb begin
        case (r_idx)
            2'd0:    w_ext_byte = {16'h0000, w_b};
            2'd1:    w_ext_byte = {8'h00, w_b, 8'h00};
            default: w_ext_byte = {w_b, 16'h0000};
        endcase
    end

    assign w_ext_len  = r_field_len | w_ext_byte[LENGTH_BITS-1:0];
    assign w_pfx_len  = LENGTH_BITS'(w_b);
    assign w_bl_dec   = r_bytes_left - LENGTH_BITS'(1);
    assign w_bl_one   = (r_bytes_left == LENGTH_BITS'(1));
    assign w_short    = (w_b < PREFIX_EXT);
    assign w_ext_last = (r_idx == EXT_LAST_IDX);
    assign w_o1       = (r_phase == PH_PREFIX) ? 2'd1 : r_off + 2'd1;
    assign w_pad      = 2'd0 - w_o1;
    assign w_pad0     = (w_pad == 2'd0);

    // Field length reached: either complete now or pad to the boundary
    always_comb begin
        unique case (r_phase)
            PH_PREFIX:  w_fin = w_short && (w_pfx_len == '0);
            PH_EXTLEN:  w_fin = w_ext_last && (w_ext_len == '0);
            PH_PAYLOAD: w_fin = w_bl_one;
            default:    w_fin = 1'b0;
        endcase
    end

    // Next phase
    always_comb begin
        unique case (r_phase)
            PH_PREFIX: begin
                if (w_b == PREFIX_BAD)      w_step_phase = PH_DROP;
                else if (w_b == PREFIX_EXT) w_step_phase = PH_EXTLEN;
                else if (w_fin)             w_step_phase = w_pad0 ? PH_PREFIX : PH_PAD;
                else                        w_step_phase = PH_PAYLOAD;
            end
            PH_EXTLEN: begin
                if (!w_ext_last)            w_step_phase = PH_EXTLEN;
                else if (w_fin)             w_step_phase = w_pad0 ? PH_PREFIX : PH_PAD;
                else                        w_step_phase = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                if (w_fin)                  w_step_phase = w_pad0 ? PH_PREFIX : PH_PAD;
                else                        w_step_phase = PH_PAYLOAD;
            end
            PH_PAD:     w_step_phase = w_bl_one ? PH_PREFIX : PH_PAD;
            PH_DROP:    w_step_phase = PH_DROP;
            default:    w_step_phase = PH_PREFIX;
        endcase
        w_open  = (w_step_phase == PH_EXTLEN) || (w_step_phase == PH_PAYLOAD) ||
                  (w_step_phase == PH_PAD);
        n_phase = r_phase;
        if (w_acc) begin
            n_phase = w_end ? PH_PREFIX : w_step_phase;
        end
    end

    // Counters and length
    always_comb begin
        n_field_len  = r_field_len;
        n_bytes_left = r_bytes_left;
        n_off        = r_off;
        n_idx        = r_idx;
        if (w_acc) begin
            unique case (r_phase)
                PH_PREFIX: begin
                    n_field_len  = w_short ? w_pfx_len : '0;
                    n_bytes_left = w_pfx_len;
                    n_off        = (w_b == PREFIX_BAD) ? 2'd0 : 2'd1;
                    n_idx        = 2'd0;
                end
                PH_EXTLEN: begin
                    n_field_len  = w_ext_len;
                    n_bytes_left = w_ext_len;
                    n_off        = w_o1;
                    n_idx        = w_ext_last ? 2'd0 : r_idx + 2'd1;
                end
                PH_PAYLOAD: begin
                    n_bytes_left = w_bl_dec;
                    n_off        = w_o1;
                end
                PH_PAD: begin
                    n_bytes_left = w_bl_dec;
                    n_off        = w_bl_one ? 2'd0 : w_o1;
                end
                default: begin
                end
            endcase
            // finish: pad count or boundary reached
            if (w_fin) begin
                if (w_pad0) n_off = 2'd0;
                else        n_bytes_left = LENGTH_BITS'(w_pad);
            end
            // buffer end closes everything
            if (w_end) begin
                n_bytes_left = '0;
                n_off        = 2'd0;
                n_idx        = 2'd0;
            end
        end
    end

    // Result events and queue entry
    always_comb begin
        ev_byte  = (r_phase == PH_PAYLOAD);
        ev_done  = ((r_phase == PH_PAD) && w_bl_one) || (w_fin && w_pad0);
        ev_bad   = (r_phase == PH_PREFIX) && (w_b == PREFIX_BAD);
        ev_trunc = w_end && w_open;

        w_res_byte  = '{kind: KIND_PAYLOAD, payload_byte: w_b, field_length: '0,
                        error_code: 1'b0};
        w_res_done  = '{kind: KIND_DONE, payload_byte: 8'h00,
                        field_length: LEN_W'(n_field_len), error_code: 1'b0};
        w_res_bad   = '{kind: KIND_ERROR, payload_byte: 8'h00, field_length: '0,
                        error_code: ERR_BAD_PREFIX};
        w_res_trunc = '{kind: KIND_ERROR, payload_byte: 8'h00, field_length: '0,
                        error_code: ERR_TRUNCATED};

        o_op.two = ev_byte && (ev_done || ev_trunc);
        o_op.r1  = ev_done ? w_res_done : w_res_trunc;
        if (ev_byte)      o_op.r0 = w_res_byte;
        else if (ev_done) o_op.r0 = w_res_done;
        else if (ev_bad)  o_op.r0 = w_res_bad;
        else              o_op.r0 = w_res_trunc;

        o_push = w_acc && (ev_byte || ev_done || ev_bad || ev_trunc);
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_PREFIX;
            r_field_len  <= '0;
            r_bytes_left <= '0;
            r_off        <= 2'd0;
            r_idx        <= 2'd0;
        end else begin
            r_phase      <= n_phase;
            r_field_len  <= n_field_len;
            r_bytes_left <= n_bytes_left;
            r_off        <= n_off;
            r_idx        <= n_idx;
        end
    end

`ifndef SYNTHESIS
    // a request carrying buffer end leaves the parser waiting for a prefix
    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && w_end |=> (r_phase == PH_PREFIX) && (r_off == 2'd0))
        else $error("buffer end did not return parser to prefix");

    // padding count stays within one word
    a_pad_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAD) |-> (r_bytes_left != '0) && (r_bytes_left < LENGTH_BITS'(4)))
        else $error("padding count out of range");
`endif

endmodule

[design/tbfd_queue.sv]
// ----------------------------------------------------------------------------
// tbfd_queue - decoupling queue
// Small register FIFO of result entries between parser and issue stage.
// ----------------------------------------------------------------------------
module tbfd_queue
    import tbfd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_op  o_op
);

    t_op                 r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wptr, r_rptr;
    logic [QPTR_W:0]     r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_op;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + QPTR_W'(1);
            if (i_pop)  r_rptr <= r_rptr + QPTR_W'(1);
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QPTR_W+1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    // fill level agrees with the pointer distance
    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == (QPTR_W+1)'(QDEPTH)) || (QPTR_W'(r_count) == QPTR_W'(r_wptr - r_rptr)))
        else $error("queue level and pointers disagree");
`endif

endmodule

[design/tbfd_back.sv]
// ----------------------------------------------------------------------------
// tbfd_back - result issue stage
// Unpacks one or two results from each queue entry into a registered
// output channel, one result per cycle while the output is ready.
// ----------------------------------------------------------------------------
module tbfd_back
    import tbfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_op         i_op,
    output logic        o_pop,
    tbfd_out_if.source  o_out
);

    logic    r_valid;
    t_result r_res;
    logic    r_last;
    logic    r_sub;

    logic    w_load;
    logic    w_last;

    // Load when the output register is free or being drained
    assign w_load = i_valid && (!r_valid || o_out.ready);
    assign w_last = r_sub || !i_op.two;
    assign o_pop  = w_load && w_last;

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res  <= r_sub ? i_op.r1 : i_op.r0;
            r_last <= w_last;
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            if (w_load)           r_valid <= 1'b1;
            else if (o_out.ready) r_valid <= 1'b0;
            if (w_load)           r_sub   <= !w_last;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.kind         = r_res.kind;
    assign o_out.payload_byte = r_res.payload_byte;
    assign o_out.field_length = r_res.field_length;
    assign o_out.error_code   = r_res.error_code;
    assign o_out.last_of_run  = r_last;

`ifndef SYNTHESIS
    // second half is only pending while its paired entry is still queued
    a_sub_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> i_valid && i_op.two)
        else $error("second result pending without a paired entry");
`endif

endmodule

[design/tl_bytes_field_deframer.sv]
// ----------------------------------------------------------------------------
// tl_bytes_field_deframer - length-prefixed byte-string field deframer
// Parses a byte stream of length-prefixed fields and emits payload bytes,
// field-complete records and error records.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while the queue is not full. Each byte
// is parsed in the cycle it is taken and its results (none, one or two) are
// written to a four-entry queue; the issue stage drains the queue into a
// registered output at one result per cycle while the output is ready. Results
// pass the queue and the output register. Padding, prefix and length bytes give
// no result unless they close a field, carry a bad prefix or meet buffer end
// inside a field; a payload byte that closes a field on a word boundary, or
// that meets buffer end inside a field, gives two results, so the sustained
// rate is one byte per cycle while results keep pace with bytes, and the
// output port sets the rate where two-result bytes cluster.
// ----------------------------------------------------------------------------
module tl_bytes_field_deframer
    import tbfd_pkg::*;
#(
    parameter int LENGTH_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tbfd_in_if.sink     i_in,
    tbfd_out_if.source  o_out
);

    logic w_push, w_full, w_qvalid, w_pop;
    t_op  w_op_in, w_op_head;

    tbfd_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_op    (w_op_in)
    );

    tbfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_op_in),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_qvalid),
        .o_op    (w_op_head)
    );

    tbfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qvalid),
        .i_op    (w_op_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule
